// ===== src/carl_pkg.sv =====
// ----------------------------------------------------------------------------
// carl_pkg: shared types and constants
// Reset values of the configuration registers, verdict codes, register indexes.
// ----------------------------------------------------------------------------
package carl_pkg;
  localparam int unsigned CLIENT_SLOTS_DEF = 16;
  localparam logic [9:0]  TOKEN_COST = 10'd1000;

  localparam logic [9:0] RATE_RST  = 10'd12;
  localparam logic [9:0] BURST_RST = 10'd24;
  localparam logic [7:0] GETL_RST  = 8'd3;
  localparam logic [7:0] OTHL_RST  = 8'd1;
  localparam logic [7:0] MAXA_RST  = 8'd4;

  localparam logic [2:0] CFG_RATE  = 3'd0;
  localparam logic [2:0] CFG_BURST = 3'd1;
  localparam logic [2:0] CFG_GETL  = 3'd2;
  localparam logic [2:0] CFG_OTHL  = 3'd3;
  localparam logic [2:0] CFG_MAXA  = 3'd4;

  localparam logic CMD_ADMIT  = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [2:0] V_ADMIT   = 3'd0;
  localparam logic [2:0] V_RATE    = 3'd1;
  localparam logic [2:0] V_CONC    = 3'd2;
  localparam logic [2:0] V_BUSY    = 3'd3;
  localparam logic [2:0] V_RELEASE = 3'd4;

  // Result of one table scan, handed from a scanner to the sequencer.
  typedef struct packed {
    logic hit;    // key found
    logic spare;  // free slot exists
    logic victim; // evictable slot exists
  } scan_res_t;
endpackage

// ===== src/client_admission_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// client_admission_rate_limiter: per-client token bucket and in-flight guard
// Sequencer with two table scanners (bucket and flight), a shared refill
// multiplier and register-file client tables.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | input     | in_valid/in_ready, command, client_id, is_get, ...
//  out     | output    | out_valid/out_ready, out_verdict
//  cfg     | input     | cfg_we, cfg_index, cfg_data
//
// A guarded admit scans the bucket and flight tables at one slot a cycle,
// with allocate, refill and take steps between, and scans the flight table
// again when the global limit turns it away; a guarded finish scans the
// flight table once, and unguarded items use no scan.
// Reset clears valid bits and the active count directly; no clearing pass.
// A verdict waits in the output register; the next item is still taken, and
// its verdict holds in the last step until the register is free.
// ----------------------------------------------------------------------------
module client_admission_rate_limiter import carl_pkg::*; #(
  parameter int unsigned CLIENT_SLOTS = CLIENT_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [31:0] in_client_id,
  input  logic        in_is_get,
  input  logic        in_is_guarded,
  input  logic [47:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  localparam int unsigned IW = $clog2(CLIENT_SLOTS);

  localparam logic [3:0] S_IDLE = 4'd0, S_BSCAN = 4'd1, S_BALLOC = 4'd2,
    S_BMUL = 4'd3, S_BADD = 4'd4, S_BTAKE = 4'd5, S_FSTART = 4'd6,
    S_FSCAN = 4'd7, S_FALLOC = 4'd8, S_GLOBAL = 4'd9, S_OUT = 4'd10,
    S_GSCAN = 4'd11, S_GIVE = 4'd12;

  logic [9:0] rate_r, burst_r;
  logic [7:0] getl_r, othl_r, maxa_r, act_r;
  logic [3:0] st_r;
  logic       cmd_r, get_r, grd_r;
  logic [31:0] key_r;
  logic [47:0] now_r;
  logic [2:0] verd_r;
  logic [2:0] vout_r;
  logic       ov_r;
  logic       ok_r;  // flight slot was taken (for busy release)

  logic [CLIENT_SLOTS-1:0] bv_r, fv_r;
  logic [31:0] bkey_m [CLIENT_SLOTS];
  logic [19:0] btok_m [CLIENT_SLOTS];
  logic [47:0] bref_m [CLIENT_SLOTS];
  logic [47:0] bsee_m [CLIENT_SLOTS];
  logic [31:0] fkey_m [CLIENT_SLOTS];
  logic [7:0]  fcnt_m [CLIENT_SLOTS];
  logic [47:0] fsee_m [CLIENT_SLOTS];

  logic       bs_start, fs_start, bs_done, fs_done;
  logic [IW-1:0] bs_idx, fs_idx, bs_slot, fs_slot;
  scan_res_t  bs_res, fs_res;
  logic [IW-1:0] bslot_r, fslot_r;

  carl_scan #(.SLOTS(CLIENT_SLOTS)) u_bscan (
    .clk, .rst_n, .start(bs_start), .need_idle(1'b0), .key(key_r),
    .e_valid(bv_r[bs_idx]), .e_key(bkey_m[bs_idx]), .e_idle(1'b1),
    .e_seen(bsee_m[bs_idx]), .idx(bs_idx), .done(bs_done), .res(bs_res),
    .slot(bs_slot));

  carl_scan #(.SLOTS(CLIENT_SLOTS)) u_fscan (
    .clk, .rst_n, .start(fs_start), .need_idle(1'b1), .key(key_r),
    .e_valid(fv_r[fs_idx]), .e_key(fkey_m[fs_idx]),
    .e_idle(fcnt_m[fs_idx] == 8'd0), .e_seen(fsee_m[fs_idx]), .idx(fs_idx),
    .done(fs_done), .res(fs_res), .slot(fs_slot));

  logic [19:0] cap;
  logic [57:0] prod_r;  // elapsed * rate
  logic [19:0] tok;
  logic [58:0] sum;
  logic [7:0]  lim, fc;
  logic [47:0] dt;

  assign cap = 20'(burst_r) * 20'(TOKEN_COST);
  assign tok = btok_m[bslot_r];
  assign dt  = now_r - bref_m[bslot_r];
  assign sum = 59'(prod_r) + 59'(tok);
  assign lim = get_r ? getl_r : othl_r;
  assign fc  = fcnt_m[fslot_r];

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_verdict = vout_r;
  assign bs_start = (st_r == S_IDLE) && in_valid && in_ready &&
                    (in_command == CMD_ADMIT) && in_is_guarded;
  assign fs_start = (st_r == S_FSTART) ||
                    ((st_r == S_IDLE) && in_valid && in_ready &&
                     (in_command == CMD_FINISH) && in_is_guarded) ||
                    ((st_r == S_GLOBAL) && grd_r && act_r >= maxa_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RST; burst_r <= BURST_RST; getl_r <= GETL_RST;
      othl_r <= OTHL_RST; maxa_r <= MAXA_RST;
      st_r <= S_IDLE; ov_r <= 1'b0; act_r <= '0;
      bv_r <= '0; fv_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RATE:  rate_r  <= cfg_data;
          CFG_BURST: burst_r <= cfg_data;
          CFG_GETL:  getl_r  <= cfg_data[7:0];
          CFG_OTHL:  othl_r  <= cfg_data[7:0];
          CFG_MAXA:  maxa_r  <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (st_r == S_OUT && (!ov_r || out_ready)) begin
        ov_r <= 1'b1; vout_r <= verd_r;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: if (in_valid && in_ready) begin
          cmd_r <= in_command; key_r <= in_client_id; get_r <= in_is_get;
          grd_r <= in_is_guarded; now_r <= in_now_ms;
          if (in_command == CMD_FINISH) begin
            if (act_r != 8'd0) act_r <= act_r - 1'b1;
            verd_r <= V_RELEASE;
            st_r <= in_is_guarded ? S_GSCAN : S_OUT;
          end else begin
            st_r <= in_is_guarded ? S_BSCAN : S_GLOBAL;
          end
        end
        S_BSCAN: if (bs_done) st_r <= S_BALLOC;
        S_BALLOC: begin
          bslot_r <= bs_slot;
          if (!bs_res.hit) begin
            bv_r[bs_slot] <= 1'b1;
            bkey_m[bs_slot] <= key_r;
            btok_m[bs_slot] <= cap;
            bref_m[bs_slot] <= now_r;
          end
          bsee_m[bs_slot] <= now_r;
          st_r <= S_BMUL;
        end
        S_BMUL: begin
          // Elapsed times past 2^48 wrap are not possible: now is 48-bit.
          prod_r <= 58'(dt) * 58'(rate_r);
          st_r <= S_BADD;
        end
        S_BADD: begin
          if (now_r > bref_m[bslot_r]) begin
            btok_m[bslot_r] <= (sum > 59'(cap)) ? cap : sum[19:0];
            bref_m[bslot_r] <= now_r;
          end
          st_r <= S_BTAKE;
        end
        S_BTAKE: begin
          if (tok < 20'(TOKEN_COST)) begin
            verd_r <= V_RATE; st_r <= S_OUT;
          end else begin
            btok_m[bslot_r] <= tok - 20'(TOKEN_COST);
            st_r <= S_FSTART;
          end
        end
        S_FSTART: st_r <= S_FSCAN;
        S_FSCAN: if (fs_done) st_r <= S_FALLOC;
        S_FALLOC: begin
          fslot_r <= fs_slot;
          if (!fs_res.hit && !fs_res.spare && !fs_res.victim) begin
            verd_r <= V_CONC; st_r <= S_OUT;
          end else begin
            // A new client entry starts with no requests in flight.
            if (!fs_res.hit) begin
              fv_r[fs_slot] <= 1'b1;
              fkey_m[fs_slot] <= key_r;
              fcnt_m[fs_slot] <= 8'd0;
            end
            fsee_m[fs_slot] <= now_r;
            ok_r <= 1'b0;
            st_r <= S_GIVE;
          end
        end
        S_GIVE: begin
          // Admit: test and take the slot; finish or busy release: give back.
          if ((cmd_r == CMD_FINISH) || ok_r) begin
            if (fc != 8'd0) fcnt_m[fslot_r] <= fc - 1'b1;
            st_r <= S_OUT;
          end else if (fc >= lim) begin
            verd_r <= V_CONC; st_r <= S_OUT;
          end else begin
            fcnt_m[fslot_r] <= fc + 1'b1;
            st_r <= S_GLOBAL;
          end
        end
        S_GLOBAL: begin
          if (act_r >= maxa_r) begin
            verd_r <= V_BUSY;
            st_r <= grd_r ? S_GSCAN : S_OUT;
            ok_r <= 1'b1;
          end else begin
            act_r <= act_r + 1'b1;
            verd_r <= V_ADMIT; st_r <= S_OUT;
          end
        end
        S_GSCAN: if (fs_done) begin
          st_r <= S_OUT;
          // A hit ends the scan with the scan index still on the matching slot.
          if (fv_r[fs_idx] && fkey_m[fs_idx] == key_r) begin
            fslot_r <= fs_idx;
            fsee_m[fs_idx] <= now_r;
            st_r <= S_GIVE;
            ok_r <= ok_r | (cmd_r == CMD_FINISH);
          end
        end
        S_OUT: if (!ov_r || out_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_verdict))
    else $error("verdict dropped or changed while waiting");
  a_act_max: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_GLOBAL && act_r >= maxa_r) |=> act_r == $past(act_r))
    else $error("active count moved on busy");
  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT && ov_r && !out_ready) |=> st_r == S_OUT)
    else $error("verdict left the last step while the output was full");
endmodule

// ===== src/carl_scan.sv =====
// ----------------------------------------------------------------------------
// carl_scan: sequential table scanner
// Walks one slot a cycle, tracking the first match, first free slot and
// the oldest evictable slot. One compare unit is shared over all slots.
// ----------------------------------------------------------------------------
module carl_scan import carl_pkg::*; #(
  parameter int unsigned SLOTS = CLIENT_SLOTS_DEF,
  localparam int unsigned IW = $clog2(SLOTS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          need_idle,   // only count-zero entries may be evicted
  input  logic [31:0]   key,
  input  logic          e_valid,
  input  logic [31:0]   e_key,
  input  logic          e_idle,
  input  logic [47:0]   e_seen,
  output logic [IW-1:0] idx,
  output logic          done,
  output scan_res_t     res,
  output logic [IW-1:0] slot
);
  logic          busy_r, busy_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          hit_r, hit_nxt, sp_r, sp_nxt, vi_r, vi_nxt;
  logic [IW-1:0] hidx_r, hidx_nxt, sidx_r, sidx_nxt, vidx_r, vidx_nxt;
  logic [47:0]   best_r, best_nxt;
  logic          last;

  assign idx  = idx_r;
  assign last = (idx_r == IW'(SLOTS - 1));

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    hit_nxt  = hit_r;  hidx_nxt = hidx_r;
    sp_nxt   = sp_r;   sidx_nxt = sidx_r;
    vi_nxt   = vi_r;   vidx_nxt = vidx_r;
    best_nxt = best_r;
    done     = 1'b0;
    if (start) begin
      busy_nxt = 1'b1; idx_nxt = '0;
      hit_nxt = 1'b0; sp_nxt = 1'b0; vi_nxt = 1'b0;
    end else if (busy_r) begin
      if (e_valid) begin
        if (e_key == key) begin
          hit_nxt = 1'b1; hidx_nxt = idx_r;
        end else if ((e_idle || !need_idle) && (!vi_r || e_seen < best_r)) begin
          vi_nxt = 1'b1; vidx_nxt = idx_r; best_nxt = e_seen;
        end
      end else if (!sp_r) begin
        sp_nxt = 1'b1; sidx_nxt = idx_r;
      end
      if ((e_valid && e_key == key) || last) begin
        busy_nxt = 1'b0;
        done = 1'b1;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
    hit_r <= hit_nxt; hidx_r <= hidx_nxt;
    sp_r  <= sp_nxt;  sidx_r <= sidx_nxt;
    vi_r  <= vi_nxt;  vidx_r <= vidx_nxt;
    best_r <= best_nxt;
  end

  // Results are taken the cycle after done, from the registers.
  assign res  = '{hit: hit_r, spare: sp_r, victim: vi_r};
  assign slot = hit_r ? hidx_r : (sp_r ? sidx_r : vidx_r);

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> busy_r) else $error("scan done while idle");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("scan restarted while busy");
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !busy_r) else $error("scan kept running after done");
endmodule
